FILE: src/bpq_pkg.sv
// shared types, constants and helpers for the bounded priority queue
package bpq_pkg;

    localparam int CAPACITY = 64;
    localparam int PRIO_W   = 8;
    localparam int ID_W     = 16;
    localparam int KEY_W    = PRIO_W + ID_W;
    localparam int COUNT_W  = 7;
    localparam int NEXT_W   = ID_W + 1;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic              cmd;
        logic [PRIO_W-1:0] priority_req;
        logic [ID_W-1:0]   id;
    } in_t;

    typedef struct packed
    {
        logic [1:0]         status;
        logic [PRIO_W-1:0]  out_priority;
        logic [ID_W-1:0]    out_id;
        logic               top_valid;
        logic [PRIO_W-1:0]  top_priority;
        logic [ID_W-1:0]    top_id;
        logic [COUNT_W-1:0] count;
        logic [NEXT_W-1:0]  next_id;
    } out_t;

    // one cell's contents: entry and the largest id held from this cell down
    typedef struct packed
    {
        logic            valid;
        key_t            key;
        logic [ID_W-1:0] smax;
    } cell_t;

    // operation broadcast to every cell
    typedef struct packed
    {
        logic ins;
        logic rem;
        key_t key;
    } op_t;

    function automatic logic [ID_W-1:0] key_id(input key_t k);
        return k[ID_W-1:0];
    endfunction

    function automatic logic [PRIO_W-1:0] key_prio(input key_t k);
        return k[KEY_W-1:ID_W];
    endfunction

    function automatic logic [ID_W-1:0] id_max(input logic [ID_W-1:0] a,
                                               input logic [ID_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: src/bpq_cell.sv
// one cell of the sorted row: holds an entry and the id maximum of its tail
module bpq_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  bpq_pkg::op_t   op,
    input  bpq_pkg::cell_t above,
    input  logic           above_ge,
    input  bpq_pkg::cell_t below,
    output bpq_pkg::cell_t state,
    output bpq_pkg::cell_t state_next,
    output logic           ge
);
    import bpq_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    key_t            key_reg;
    key_t            key_next;
    logic [ID_W-1:0] smax_reg;
    logic [ID_W-1:0] smax_next;
    logic [ID_W-1:0] eff_smax;

    assign ge       = valid_reg && (key_reg >= op.key);
    assign eff_smax = valid_reg ? smax_reg : '0;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        smax_next  = smax_reg;
        if (op.ins)
        begin
            if (ge)
            begin
                smax_next = id_max(smax_reg, key_id(op.key));
            end
            else if (above_ge)
            begin
                // new entry lands here, old contents move one cell down
                valid_next = 1'b1;
                key_next   = op.key;
                smax_next  = id_max(key_id(op.key), eff_smax);
            end
            else
            begin
                valid_next = above.valid;
                key_next   = above.key;
                smax_next  = above.smax;
            end
        end
        else if (op.rem)
        begin
            valid_next = below.valid;
            key_next   = below.key;
            smax_next  = below.smax;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        smax_reg <= smax_next;
    end

    assign state      = '{valid: valid_reg, key: key_reg, smax: smax_reg};
    assign state_next = '{valid: valid_next, key: key_next, smax: smax_next};

endmodule

FILE: src/bpq_chain.sv
// row of cells kept in descending key order, maximum at cell 0
module bpq_chain
(
    input  logic           clk,
    input  logic           rst_n,
    input  bpq_pkg::op_t   op,
    output bpq_pkg::cell_t head,
    output bpq_pkg::cell_t head_next
);
    import bpq_pkg::*;

    cell_t cells [CAPACITY];
    cell_t nexts [CAPACITY];
    logic  ge    [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_t above;
        cell_t below;
        logic  above_ge;

        if (i == 0)
        begin : g_first
            assign above    = '0;
            assign above_ge = 1'b1;
        end
        else
        begin : g_mid
            assign above    = cells[i-1];
            assign above_ge = ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = cells[i+1];
        end

        bpq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .above      (above),
            .above_ge   (above_ge),
            .below      (below),
            .state      (cells[i]),
            .state_next (nexts[i]),
            .ge         (ge[i])
        );
    end

    assign head      = cells[0];
    assign head_next = nexts[0];

endmodule

FILE: src/bounded_priority_queue.sv
// Bounded max-priority queue of up to 64 {priority, id} entries kept in a row of
// compare-and-shift cells, largest key (priority, then id) at the head. Every
// transfer is handled in parallel: all cells compare against the new key at once
// and shift by one place, so an item is taken each cycle while results are
// being taken, and its result appears in the output register on the next
// cycle. A result left waiting in the output register holds off the next input
// until it is taken. Each cell also carries the largest id of itself and the
// cells behind it, so next_id comes from the head cell without any search. A
// remove on an empty queue or an insert on a full one leaves the contents
// untouched and reports its status.
module bounded_priority_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bpq_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bpq_pkg::out_t out_data
);
    import bpq_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    logic               accept;
    logic               is_insert;
    logic               full;
    logic               empty;
    op_t                op;
    cell_t              head;
    cell_t              head_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_t               out_reg;
    out_t               result;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_insert = (in_data.cmd == CMD_INSERT);
    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);

    assign op.ins = accept && is_insert && !full;
    assign op.rem = accept && !is_insert && !empty;
    assign op.key = {in_data.priority_req, in_data.id};

    bpq_chain u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .head      (head),
        .head_next (head_next)
    );

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.rem)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        result = '0;
        if (is_insert && full)
        begin
            result.status = ST_FULL;
        end
        else if (!is_insert && empty)
        begin
            result.status = ST_EMPTY;
        end
        else
        begin
            result.status = ST_OK;
        end
        if (op.rem)
        begin
            result.out_priority = key_prio(head.key);
            result.out_id       = key_id(head.key);
        end
        result.count     = count_next;
        result.top_valid = head_next.valid;
        if (head_next.valid)
        begin
            result.top_priority = key_prio(head_next.key);
            result.top_id       = key_id(head_next.key);
            result.next_id      = {1'b0, head_next.smax} + 1'b1;
        end
        else
        begin
            result.next_id = NEXT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // count stays within the row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond capacity");

    // head cell occupancy tracks the count
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid == (count_reg != '0))
        else $error("head cell valid disagrees with count");

    // a held result reports a top entry exactly when entries remain
    a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.top_valid == (out_reg.count != '0)))
        else $error("top_valid disagrees with count");

    // remove on an empty queue reports empty and leaves it empty
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_insert && empty) |=>
            (out_reg.status == ST_EMPTY) && (count_reg == '0))
        else $error("remove on empty queue mishandled");

endmodule
